// File: rtl/rwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared types, constants and helpers of the textured wall column block.
// ----------------------------------------------------------------------------
package rwc_pkg;

    localparam int TEX_WIDTH_DEF  = 64;
    localparam int TEX_HEIGHT_DEF = 64;
    localparam int MAX_ROWS_DEF   = 1024;

    // Divider: dividend is |num| << 16 (39 bits), divisor up to 32 bits.
    localparam int DVD_W = 39;
    localparam int DVS_W = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [31:0] DIST_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
    localparam logic [23:0] Q24_MAX    = 24'hFF_FFFF;

    localparam logic       KIND_SETUP = 1'b0;
    localparam logic       KIND_ROW   = 1'b1;

    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_CEILING_COLOR = 2'd1;
    localparam logic [1:0] CFG_FLOOR_COLOR   = 2'd2;

    localparam logic [1:0] CLS_CEILING = 2'd0;
    localparam logic [1:0] CLS_WALL    = 2'd1;
    localparam logic [1:0] CLS_FLOOR   = 2'd2;
    localparam logic [1:0] CLS_SETUP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_HEIGHT,
        ST_STEP,
        ST_TPOS,
        ST_EMIT
    } t_state;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic               kind;
        logic [1:0]         side;
        logic [15:0]        pos_b;
        logic signed [17:0] dir_a;
        logic signed [17:0] dir_b;
        logic signed [23:0] num;
        logic [9:0]         row;
        logic [10:0]        column;
    } t_item;

    function automatic logic [1:0] tex_of_side(input logic [1:0] side);
        logic [1:0] sel;
        case (side)
            2'd0:    sel = 2'd2;
            2'd1:    sel = 2'd1;
            2'd2:    sel = 2'd3;
            default: sel = 2'd0;
        endcase
        return sel;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rwc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_front
// Accepts input items, picks the ray axis for setups and forms the distance
// numerator, then hands the item to the queue.
// ----------------------------------------------------------------------------
module rwc_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_kind,
    input  wire logic [21:0]         i_pos_x,
    input  wire logic [21:0]         i_pos_y,
    input  wire logic signed [17:0]  i_dir_x,
    input  wire logic signed [17:0]  i_dir_y,
    input  wire logic [5:0]          i_cell_x,
    input  wire logic [5:0]          i_cell_y,
    input  wire logic signed [1:0]   i_step_sign_x,
    input  wire logic signed [1:0]   i_step_sign_y,
    input  wire logic [1:0]          i_wall_side,
    input  wire logic [9:0]          i_row,
    input  wire logic [10:0]         i_column,
    output logic                     o_q_valid,
    input  wire logic                i_q_ready,
    output rwc_pkg::t_item           o_q_item
);
    import rwc_pkg::*;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic        w_xface;
    logic [21:0] w_pos_a;
    logic [5:0]  w_cell;
    logic        w_neg;
    logic [6:0]  w_cell_off;

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

    always_comb begin
        w_xface    = (i_wall_side == 2'd0) || (i_wall_side == 2'd2);
        w_pos_a    = w_xface ? i_pos_x : i_pos_y;
        w_cell     = w_xface ? i_cell_x : i_cell_y;
        w_neg      = w_xface ? i_step_sign_x[1] : i_step_sign_y[1];
        w_cell_off = {1'b0, w_cell} + {6'd0, w_neg};
        n_item.kind   = i_kind;
        n_item.side   = i_wall_side;
        n_item.pos_b  = w_xface ? i_pos_y[15:0] : i_pos_x[15:0];
        n_item.dir_a  = w_xface ? i_dir_x : i_dir_y;
        n_item.dir_b  = w_xface ? i_dir_y : i_dir_x;
        n_item.num    = signed'({1'b0, w_cell_off, 16'd0}) - signed'({2'b00, w_pos_a});
        n_item.row    = i_row;
        n_item.column = i_column;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rwc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rwc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire rwc_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop,
    output rwc_pkg::t_item      o_pop_item
);
    import rwc_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rwc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwc_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rwc_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [rwc_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [rwc_pkg::DVD_W-1:0]       o_quotient
);
    import rwc_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W:0]   w_diff;

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

// File: rtl/rwc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_back
// Carries out queued items: the column setup sequence over the shared
// divider, and the per-row classing and texture walk.
// ----------------------------------------------------------------------------
module rwc_back #(
    parameter int TEX_WIDTH  = rwc_pkg::TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = rwc_pkg::TEX_HEIGHT_DEF,
    parameter int MAX_ROWS   = rwc_pkg::MAX_ROWS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    output logic                o_q_pop,
    input  wire rwc_pkg::t_item i_q_item,
    input  wire logic [10:0]    i_screen_height,
    input  wire logic [23:0]    i_ceiling_color,
    input  wire logic [23:0]    i_floor_color,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_pixel_class,
    output logic [23:0]         o_flat_color,
    output logic [1:0]          o_texture_select,
    output logic [5:0]          o_texel_x,
    output logic [5:0]          o_texel_y,
    output logic [9:0]          o_out_row,
    output logic [10:0]         o_out_column,
    output logic [9:0]          o_span_top,
    output logic [9:0]          o_span_bottom
);
    import rwc_pkg::*;

    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam logic [7:0] TY_MAX = 8'((TEX_HEIGHT - 1 < 63) ? TEX_HEIGHT - 1 : 63);
    localparam logic [8:0] TW_M1  = 9'(TEX_WIDTH - 1);

    t_state r_state, n_state;

    // Column state.
    logic [9:0]  r_span_start, r_span_end;
    logic [5:0]  r_tex_column;
    logic [1:0]  r_tex_choice;
    logic [23:0] r_tex_step, r_tex_position;

    // Setup working registers.
    logic [1:0]         r_side;
    logic [15:0]        r_pos_b;
    logic signed [17:0] r_dir_a, r_dir_b;
    logic [10:0]        r_column;
    logic [31:0]        r_dist;
    logic [15:0]        r_height;
    logic [16:0]        r_top, r_bot;
    logic [15:0]        r_factor;
    logic [15:0]        r_prod_hi;
    logic [23:0]        r_step;
    logic [5:0]         r_tc;
    logic               r_num_neg_q;

    // Output register.
    logic        r_o_valid;
    logic [1:0]  r_o_class;
    logic [23:0] r_o_flat;
    logic [1:0]  r_o_tsel;
    logic [5:0]  r_o_tx, r_o_ty;
    logic [9:0]  r_o_row;
    logic [10:0] r_o_col;
    logic [9:0]  r_o_top, r_o_bot;

    logic             w_out_free;
    logic             w_pop_setup, w_pop_row, w_emit_setup, w_commit;
    logic             w_div_start;
    logic [DVD_W-1:0] w_div_dvd;
    logic [DVS_W-1:0] w_div_dvs;
    logic             w_div_done;
    logic [DVD_W-1:0] w_div_q;

    logic [HW-1:0]    w_h;
    logic [16:0]      w_hh;
    logic             w_num_neg, w_dir_neg;
    logic [22:0]      w_num_mag;
    logic [17:0]      w_dir_mag;
    logic [31:0]      w_dist;
    logic [15:0]      w_height;
    logic [16:0]      w_hg;
    logic [16:0]      w_bot_raw;
    logic [31:0]      w_prod;
    logic [23:0]      w_step;
    logic [15:0]      w_hit;
    logic [24:0]      w_hit_scaled;
    logic [8:0]       w_tc_raw;
    logic [8:0]       w_tc;
    logic             w_mirror;
    logic [39:0]      w_tp_full;
    logic [23:0]      w_tp;

    logic [1:0]       w_row_class;
    logic [7:0]       w_ty_raw;
    logic [5:0]       w_ty;
    logic [24:0]      w_np;

    rwc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_out_free = !r_o_valid || i_ready;

    // Rows in use, forced into 1..MAX_ROWS.
    always_comb begin
        if (i_screen_height == 11'd0) begin
            w_h = HW'(1);
        end else if (32'(i_screen_height) > 32'(MAX_ROWS)) begin
            w_h = HW'(MAX_ROWS);
        end else begin
            w_h = HW'(i_screen_height);
        end
        w_hh = 17'(w_h >> 1);
    end

    // Setup arithmetic.
    always_comb begin
        w_num_neg = i_q_item.num[23];
        w_num_mag = w_num_neg ? 23'(-i_q_item.num) : i_q_item.num[22:0];
        w_dir_neg = i_q_item.dir_a[17];
        w_dir_mag = w_dir_neg ? 18'(-i_q_item.dir_a) : 18'(i_q_item.dir_a);

        // Distance: a zero direction saturates, a negative quotient clamps to zero.
        if (r_dir_a == 18'sd0) begin
            w_dist = DIST_MAX;
        end else if (w_div_q > DVD_W'(DIST_MAX)) begin
            w_dist = DIST_MAX;
        end else begin
            w_dist = w_div_q[31:0];
        end

        if (r_dist == 32'd0) begin
            w_height = HEIGHT_MAX;
        end else if (w_div_q > DVD_W'(HEIGHT_MAX)) begin
            w_height = HEIGHT_MAX;
        end else begin
            w_height = w_div_q[15:0];
        end
        w_hg      = 17'(w_height >> 1);
        w_bot_raw = w_hg + w_hh;

        w_prod = r_dist * {{14{r_dir_b[17]}}, r_dir_b};

        if (r_height == 16'd0) begin
            w_step = Q24_MAX;
        end else if (w_div_q > DVD_W'(Q24_MAX)) begin
            w_step = Q24_MAX;
        end else begin
            w_step = w_div_q[23:0];
        end

        w_hit        = r_pos_b + r_prod_hi;
        w_hit_scaled = 25'(w_hit) * 25'(TEX_WIDTH);
        w_tc_raw     = w_hit_scaled[24:16];
        w_mirror     = ((r_side == 2'd0) && !r_dir_a[17] && (r_dir_a != 18'sd0))
                    || ((r_side == 2'd1) && r_dir_a[17]);
        w_tc         = w_mirror ? (TW_M1 - w_tc_raw) : w_tc_raw;

        w_tp_full = 40'(r_factor) * 40'(r_step);
        w_tp      = (w_tp_full > 40'(Q24_MAX)) ? Q24_MAX : w_tp_full[23:0];
    end

    // Row classing and texture walk.
    always_comb begin
        w_ty_raw = r_tex_position[23:16];
        w_ty     = (w_ty_raw > TY_MAX) ? TY_MAX[5:0] : w_ty_raw[5:0];
        w_np     = {1'b0, r_tex_position} + {1'b0, r_tex_step};
        if (i_q_item.row < r_span_start) begin
            w_row_class = CLS_CEILING;
        end else if ((i_q_item.row <= r_span_end)
                     && (32'(i_q_item.row) < 32'(w_h))) begin
            w_row_class = CLS_WALL;
        end else begin
            w_row_class = CLS_FLOOR;
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        w_pop_setup  = 1'b0;
        w_pop_row    = 1'b0;
        w_emit_setup = 1'b0;
        w_commit     = 1'b0;
        w_div_start  = 1'b0;
        w_div_dvd    = {w_num_mag, 16'd0};
        w_div_dvs    = DVS_W'(w_dir_mag);
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == KIND_SETUP) begin
                        w_pop_setup = 1'b1;
                        w_div_start = 1'b1;
                        n_state     = ST_DIST;
                    end else if (w_out_free) begin
                        w_pop_row = 1'b1;
                    end
                end
            end
            ST_DIST: begin
                w_div_dvd = DVD_W'({w_h, 16'd0});
                w_div_dvs = w_dist;
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_HEIGHT;
                end
            end
            ST_HEIGHT: begin
                w_div_dvd = DVD_W'(TEX_HEIGHT) << 16;
                w_div_dvs = DVS_W'(w_height);
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_div_done) begin
                    n_state = ST_TPOS;
                end
            end
            ST_TPOS: begin
                w_commit = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_emit_setup = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_q_pop = w_pop_setup || w_pop_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Setup working registers.
    always_ff @(posedge i_clk) begin
        if (w_pop_setup) begin
            r_side   <= i_q_item.side;
            r_pos_b  <= i_q_item.pos_b;
            r_dir_a  <= i_q_item.dir_a;
            r_dir_b  <= i_q_item.dir_b;
            r_column <= i_q_item.column;
        end
        if (r_state == ST_DIST && w_div_done) begin
            // Opposite signs give a negative quotient, which clamps to zero.
            if (r_dir_a == 18'sd0) begin
                r_dist <= DIST_MAX;
            end else if (r_num_neg_q != r_dir_a[17]) begin
                r_dist <= 32'd0;
            end else begin
                r_dist <= w_dist;
            end
        end
        if (r_state == ST_HEIGHT && w_div_done) begin
            r_height  <= w_height;
            r_top     <= (w_hh > w_hg) ? (w_hh - w_hg) : 17'd0;
            r_bot     <= (32'(w_bot_raw) >= 32'(w_h)) ? 17'(w_h - 1'b1) : w_bot_raw;
            r_factor  <= (w_hg > w_hh) ? 16'(w_hg - w_hh) : 16'd0;
            r_prod_hi <= w_prod[31:16];
        end
        if (r_state == ST_STEP && w_div_done) begin
            r_step <= w_step;
            r_tc   <= w_tc[5:0];
        end
    end

    // Sign of the numerator of the item under setup; a zero numerator counts
    // as a sign mismatch so that the distance becomes zero.
    always_ff @(posedge i_clk) begin
        if (w_pop_setup) begin
            r_num_neg_q <= (i_q_item.num == 24'sd0) ? !w_dir_neg : w_num_neg;
        end
    end

    // Column state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_start   <= '0;
            r_span_end     <= '0;
            r_tex_column   <= '0;
            r_tex_choice   <= '0;
            r_tex_step     <= '0;
            r_tex_position <= '0;
        end else if (w_commit) begin
            r_span_start   <= r_top[9:0];
            r_span_end     <= r_bot[9:0];
            r_tex_column   <= r_tc;
            r_tex_choice   <= r_side;
            r_tex_step     <= r_step;
            r_tex_position <= w_tp;
        end else if (w_pop_row && w_row_class == CLS_WALL) begin
            r_tex_position <= w_np[24] ? Q24_MAX : w_np[23:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_pop_row || w_emit_setup) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_row) begin
            r_o_class <= w_row_class;
            r_o_flat  <= (w_row_class == CLS_CEILING) ? i_ceiling_color
                       : (w_row_class == CLS_FLOOR) ? i_floor_color : 24'd0;
            r_o_tsel  <= (w_row_class == CLS_WALL) ? tex_of_side(r_tex_choice) : 2'd0;
            r_o_tx    <= (w_row_class == CLS_WALL) ? r_tex_column : 6'd0;
            r_o_ty    <= (w_row_class == CLS_WALL) ? w_ty : 6'd0;
            r_o_row   <= i_q_item.row;
            r_o_col   <= i_q_item.column;
            r_o_top   <= r_span_start;
            r_o_bot   <= r_span_end;
        end else if (w_emit_setup) begin
            r_o_class <= CLS_SETUP;
            r_o_flat  <= 24'd0;
            r_o_tsel  <= tex_of_side(r_tex_choice);
            r_o_tx    <= r_tex_column;
            r_o_ty    <= 6'd0;
            r_o_row   <= 10'd0;
            r_o_col   <= r_column;
            r_o_top   <= r_span_start;
            r_o_bot   <= r_span_end;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_pixel_class    = r_o_class;
    assign o_flat_color     = r_o_flat;
    assign o_texture_select = r_o_tsel;
    assign o_texel_x        = r_o_tx;
    assign o_texel_y        = r_o_ty;
    assign o_out_row        = r_o_row;
    assign o_out_column     = r_o_col;
    assign o_span_top       = r_o_top;
    assign o_span_bottom    = r_o_bot;

endmodule
`default_nettype wire

// File: rtl/raycast_wall_column_texturer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// Textured wall column of a grid raycaster in fixed point. A setup item
// computes the wall distance, span, texture column, step and start position;
// each row item is then classed as ceiling, wall or floor.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Carries
//  input     in         i_valid / o_ready          one setup or row item
//  result    out        o_valid / i_ready          one result item per input
//  config    in         i_cfg_valid / o_cfg_ready  register index and data
//
// Row items stream one per cycle while no setup is in progress and the result channel accepts them.
// A setup item holds the back end while three divisions (distance, line
// height, texture step) run in turn on the shared bit-serial divider, each
// yielding a 39-bit quotient, then it commits and emits.
// Reset is synchronous and active low; it clears control and column state.
// A four-entry queue lets the front and back stall independently.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer #(
    parameter int TEX_WIDTH  = rwc_pkg::TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = rwc_pkg::TEX_HEIGHT_DEF,
    parameter int MAX_ROWS   = rwc_pkg::MAX_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [21:0]        i_pos_x,
    input  wire logic [21:0]        i_pos_y,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic [5:0]         i_cell_x,
    input  wire logic [5:0]         i_cell_y,
    input  wire logic signed [1:0]  i_step_sign_x,
    input  wire logic signed [1:0]  i_step_sign_y,
    input  wire logic [1:0]         i_wall_side,
    input  wire logic [9:0]         i_row,
    input  wire logic [10:0]        i_column,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_pixel_class,
    output logic [23:0]             o_flat_color,
    output logic [1:0]              o_texture_select,
    output logic [5:0]              o_texel_x,
    output logic [5:0]              o_texel_y,
    output logic [9:0]              o_out_row,
    output logic [10:0]             o_out_column,
    output logic [9:0]              o_span_top,
    output logic [9:0]              o_span_bottom,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import rwc_pkg::*;

    // Configuration registers. Writes are always taken; an index past the
    // register list is accepted and ignored.
    logic [10:0] r_screen_height;
    logic [23:0] r_ceiling_color;
    logic [23:0] r_floor_color;

    logic  w_f_valid, w_f_ready;
    t_item w_f_item;
    logic  w_q_valid, w_q_pop;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= 11'd480;
            r_ceiling_color <= 24'd0;
            r_floor_color   <= 24'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[10:0];
                CFG_CEILING_COLOR: r_ceiling_color <= i_cfg_data;
                CFG_FLOOR_COLOR:   r_floor_color   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: takes items and picks the ray axis for setups.
    rwc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_step_sign_x (i_step_sign_x),
        .i_step_sign_y (i_step_sign_y),
        .i_wall_side   (i_wall_side),
        .i_row         (i_row),
        .i_column      (i_column),
        .o_q_valid     (w_f_valid),
        .i_q_ready     (w_f_ready),
        .o_q_item      (w_f_item)
    );

    // Queue that decouples the front end from the back end.
    rwc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_item  (w_f_item),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_item   (w_q_item)
    );

    // Back end: setup sequence, row classing and the result register.
    rwc_back #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .o_q_pop          (w_q_pop),
        .i_q_item         (w_q_item),
        .i_screen_height  (r_screen_height),
        .i_ceiling_color  (r_ceiling_color),
        .i_floor_color    (r_floor_color),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_class    (o_pixel_class),
        .o_flat_color     (o_flat_color),
        .o_texture_select (o_texture_select),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y),
        .o_out_row        (o_out_row),
        .o_out_column     (o_out_column),
        .o_span_top       (o_span_top),
        .o_span_bottom    (o_span_bottom)
    );

`ifndef NO_ASSERTIONS
    // A full queue always has an item to give.
    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_f_ready |-> w_q_valid)
        else $error("queue reports full while empty");

    // Wall and setup results never carry a flat color.
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pixel_class == CLS_WALL || o_pixel_class == CLS_SETUP))
        |-> (o_flat_color == 24'd0))
        else $error("flat color on a wall or setup result");

    // Only wall rows carry a texel row.
    a_texel_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_class != CLS_WALL) |-> (o_texel_y == 6'd0))
        else $error("texel row on a non-wall result");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !w_q_valid && !w_f_valid))
        else $error("items survive reset");
`endif

endmodule
`default_nettype wire
